### hdl/pbq_pkg.sv
`timescale 1ns / 1ps
// pbq_pkg: shared constants and types for the particle billboard quad expander
// no dependencies; imported by the fifo, front end, back end and top level

package pbq_pkg;

  localparam int MAX_QUADS_DEF  = 1024;
  localparam int FIFO_DEPTH_DEF = 2;
  localparam int VERTS_PER_QUAD = 6;
  localparam int SLOT_W         = 13;
  localparam int HALF_W         = 30;
  localparam int LIFE_W         = 31;
  localparam int RIGHT_W        = 16;
  localparam int CFG_AW         = 4;

  localparam logic [1:0] REG_RIGHT_X = 2'd0;
  localparam logic [1:0] REG_RIGHT_Y = 2'd1;
  localparam logic [1:0] REG_RIGHT_Z = 2'd2;

  localparam logic signed [RIGHT_W-1:0] RIGHT_X_RST = 16'sd16384;
  localparam logic signed [RIGHT_W-1:0] RIGHT_Y_RST = 16'sd0;
  localparam logic signed [RIGHT_W-1:0] RIGHT_Z_RST = 16'sd0;

  typedef struct packed {
    logic signed [RIGHT_W-1:0] x;
    logic signed [RIGHT_W-1:0] y;
    logic signed [RIGHT_W-1:0] z;
  } pbq_right_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [HALF_W-1:0]  half;
    logic [LIFE_W-1:0]  life;
    logic [LIFE_W-1:0]  total;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic [7:0]         a;
    logic [SLOT_W-1:0]  slot_base;
  } pbq_item_t;

endpackage

### hdl/pbq_if.sv
`timescale 1ns / 1ps
// pbq_in_if / pbq_out_if: valid/ready channels for particles and vertices
// no dependencies

interface pbq_in_if;
  logic               valid;
  logic               ready;
  logic               frame_start;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [30:0]        edge_size;
  logic signed [31:0] life_left;
  logic [30:0]        life_total;
  logic [7:0]         color_r;
  logic [7:0]         color_g;
  logic [7:0]         color_b;
  logic [7:0]         color_a;

  modport source (output valid, frame_start, pos_x, pos_y, pos_z, edge_size, life_left,
                  life_total, color_r, color_g, color_b, color_a, input ready);
  modport sink (input valid, frame_start, pos_x, pos_y, pos_z, edge_size, life_left,
                life_total, color_r, color_g, color_b, color_a, output ready);
endinterface

interface pbq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vert_x;
  logic signed [31:0] vert_y;
  logic signed [31:0] vert_z;
  logic [7:0]         out_r;
  logic [7:0]         out_g;
  logic [7:0]         out_b;
  logic [7:0]         out_a;
  logic [12:0]        vertex_slot;
  logic               last_vertex;

  modport source (output valid, vert_x, vert_y, vert_z, out_r, out_g, out_b, out_a,
                  vertex_slot, last_vertex, input ready);
  modport sink (input valid, vert_x, vert_y, vert_z, out_r, out_g, out_b, out_a,
                vertex_slot, last_vertex, output ready);
endinterface

### hdl/pbq_fifo.sv
`timescale 1ns / 1ps
// pbq_fifo: short register queue of particle requests between front and back end
// depends on pbq_pkg

module pbq_fifo
  import pbq_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  pbq_item_t wr_data,
  output logic      full,
  input  logic      rd_en,
  output pbq_item_t rd_data,
  output logic      empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pbq_item_t     mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          wr_ok;
  logic          rd_ok;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign wr_ok   = wr_en && !full;
  assign rd_ok   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_ok) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (rd_ok) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (wr_ok && !rd_ok) begin
        count_r <= count_r + CW'(1);
      end else if (rd_ok && !wr_ok) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

### hdl/pbq_front.sv
`timescale 1ns / 1ps
// pbq_front: accepts particles, drops dead ones and those past the quad budget,
// keeps the per-frame quad counter; depends on pbq_pkg and pbq_in_if

module pbq_front
  import pbq_pkg::*;
#(
  parameter int MAX_QUADS = MAX_QUADS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pbq_in_if.sink    in_bus,
  output logic      push,
  output pbq_item_t push_data,
  input  logic      full
);

  localparam int QCW = $clog2(MAX_QUADS + 1);
  localparam int PW  = (QCW + 3 > SLOT_W) ? QCW + 3 : SLOT_W;

  logic [QCW-1:0] quad_count_r;
  logic [QCW-1:0] quad_count_nxt;
  logic [QCW-1:0] qc_cur;
  logic [PW-1:0]  slot_prod;
  logic           take;
  logic           alive;

  assign in_bus.ready = !full;
  assign take         = in_bus.valid && !full;
  assign qc_cur       = in_bus.frame_start ? '0 : quad_count_r;
  assign alive        = !in_bus.life_left[31] && (in_bus.life_left != '0) &&
                        (qc_cur < QCW'(MAX_QUADS));
  assign slot_prod    = PW'(qc_cur) * PW'(VERTS_PER_QUAD);
  assign push         = take && alive;

  always_comb begin
    push_data.pos_x     = in_bus.pos_x;
    push_data.pos_y     = in_bus.pos_y;
    push_data.pos_z     = in_bus.pos_z;
    push_data.half      = in_bus.edge_size[30:1];
    push_data.life      = in_bus.life_left[30:0];
    push_data.total     = in_bus.life_total;
    push_data.r         = in_bus.color_r;
    push_data.g         = in_bus.color_g;
    push_data.b         = in_bus.color_b;
    push_data.a         = in_bus.color_a;
    push_data.slot_base = slot_prod[SLOT_W-1:0];
  end

  always_comb begin
    quad_count_nxt = quad_count_r;
    if (take) begin
      quad_count_nxt = alive ? qc_cur + QCW'(1) : qc_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_count_r <= '0;
    end else begin
      quad_count_r <= quad_count_nxt;
    end
  end

endmodule

### hdl/pbq_back.sv
`timescale 1ns / 1ps
// pbq_back: per particle computes the right offsets and faded alpha, then emits
// six saturated vertices; depends on pbq_pkg and pbq_out_if

module pbq_back
  import pbq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  pbq_right_t right,
  input  logic       empty,
  input  pbq_item_t  rd_data,
  output logic       pop,
  pbq_out_if.source  out_bus
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]         state_r;
  logic [1:0]         state_nxt;
  pbq_item_t          item_r;
  logic signed [32:0] rx_r;
  logic signed [32:0] ry_r;
  logic signed [32:0] rz_r;
  logic [39:0]        rem_r;
  logic [7:0]         quo_r;
  logic [2:0]         step_r;
  logic [2:0]         vidx_r;

  logic               out_valid_r;
  logic signed [31:0] vx_r;
  logic signed [31:0] vy_r;
  logic signed [31:0] vz_r;
  logic [7:0]         vr_r;
  logic [7:0]         vg_r;
  logic [7:0]         vb_r;
  logic [7:0]         va_r;
  logic [SLOT_W-1:0]  vslot_r;
  logic               vlast_r;

  logic signed [46:0] prod_x;
  logic signed [46:0] prod_y;
  logic signed [46:0] prod_z;
  logic [39:0]        num;
  logic [39:0]        dsh;
  logic               ge;
  logic [1:0]         corner;
  logic               r_pos;
  logic               u_pos;
  logic signed [34:0] half_s;
  logic signed [34:0] sum_x;
  logic signed [34:0] sum_y;
  logic signed [34:0] sum_z;
  logic [7:0]         alpha;
  logic               load;

  function automatic logic [1:0] corner_of(input logic [2:0] k);
    logic [1:0] c;
    unique case (k)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd0;
      3'd4:    c = 2'd2;
      3'd5:    c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] res;
    if ((v[34:31] == 4'b0000) || (v[34:31] == 4'b1111)) begin
      res = v[31:0];
    end else if (v[34]) begin
      res = {1'b1, 31'd0};
    end else begin
      res = {1'b0, {31{1'b1}}};
    end
    return res;
  endfunction

  assign prod_x = right.x * $signed({1'b0, item_r.half});
  assign prod_y = right.y * $signed({1'b0, item_r.half});
  assign prod_z = right.z * $signed({1'b0, item_r.half});
  assign num    = 40'(item_r.a) * 40'({item_r.life, 1'b0});
  assign dsh    = 40'(item_r.total) << step_r;
  assign ge     = (rem_r >= dsh);

  assign corner = corner_of(vidx_r);
  assign r_pos  = (corner == 2'd1) || (corner == 2'd2);
  assign u_pos  = (corner == 2'd2) || (corner == 2'd3);
  assign half_s = $signed({5'd0, item_r.half});

  always_comb begin
    sum_x = 35'($signed(item_r.pos_x)) + (r_pos ? 35'(rx_r) : -35'(rx_r));
    sum_y = 35'($signed(item_r.pos_y)) + (r_pos ? 35'(ry_r) : -35'(ry_r)) +
            (u_pos ? half_s : -half_s);
    sum_z = 35'($signed(item_r.pos_z)) + (r_pos ? 35'(rz_r) : -35'(rz_r));
  end

  // fade: zero total, saturated at full alpha, or the divider quotient
  always_comb begin
    if (item_r.total == '0) begin
      alpha = 8'd0;
    end else if ({item_r.life, 1'b0} >= {1'b0, item_r.total}) begin
      alpha = item_r.a;
    end else begin
      alpha = quo_r;
    end
  end

  assign pop  = (state_r == S_IDLE) && !empty;
  assign load = (state_r == S_EMIT) && (!out_valid_r || out_bus.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (!empty) state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (step_r == 3'd0) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (load && (vidx_r == 3'(VERTS_PER_QUAD - 1))) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= rd_data;
    end
    if (state_r == S_MUL) begin
      rx_r   <= prod_x[46:14];
      ry_r   <= prod_y[46:14];
      rz_r   <= prod_z[46:14];
      rem_r  <= num;
      quo_r  <= 8'd0;
      step_r <= 3'd7;
      vidx_r <= 3'd0;
    end
    // one quotient bit per cycle, quotient known to fit in eight bits
    if (state_r == S_DIV) begin
      rem_r  <= ge ? rem_r - dsh : rem_r;
      quo_r  <= {quo_r[6:0], ge};
      step_r <= step_r - 3'd1;
    end
    if (load) begin
      vx_r    <= sat32(sum_x);
      vy_r    <= sat32(sum_y);
      vz_r    <= sat32(sum_z);
      vr_r    <= item_r.r;
      vg_r    <= item_r.g;
      vb_r    <= item_r.b;
      va_r    <= alpha;
      vslot_r <= item_r.slot_base + SLOT_W'(vidx_r);
      vlast_r <= (vidx_r == 3'(VERTS_PER_QUAD - 1));
      vidx_r  <= vidx_r + 3'd1;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.vert_x      = vx_r;
  assign out_bus.vert_y      = vy_r;
  assign out_bus.vert_z      = vz_r;
  assign out_bus.out_r       = vr_r;
  assign out_bus.out_g       = vg_r;
  assign out_bus.out_b       = vb_r;
  assign out_bus.out_a       = va_r;
  assign out_bus.vertex_slot = vslot_r;
  assign out_bus.last_vertex = vlast_r;

endmodule

### hdl/particle_billboard_quad_expand.sv
`timescale 1ns / 1ps
// particle_billboard_quad_expand: top level with the right-vector registers
// depends on pbq_pkg, pbq_if, pbq_fifo, pbq_front, pbq_back

// Expands each particle into a camera-facing quad and emits six vertices
// (c0,c1,c2,c0,c2,c3). The front end takes one particle per cycle while its queue has
// room; dead particles and those beyond MAX_QUADS in the current frame are absorbed
// there and emit nothing. A live particle holds the back end while it is popped from
// the queue, goes through the three right-vector multipliers and the alpha numerator
// product, then the alpha divider that settles one quotient bit per cycle, and emits
// its six vertices through the output register, which waits while the sink holds ready
// low. The right vector registers are written over the cfg_ APB port.

module particle_billboard_quad_expand
  import pbq_pkg::*;
#(
  parameter int MAX_QUADS  = MAX_QUADS_DEF,
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  pbq_in_if.sink            in_bus,
  pbq_out_if.source         out_bus,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  pbq_right_t right_r;
  pbq_item_t  push_data;
  pbq_item_t  rd_data;
  logic       push;
  logic       full;
  logic       pop;
  logic       empty;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_r.x <= RIGHT_X_RST;
      right_r.y <= RIGHT_Y_RST;
      right_r.z <= RIGHT_Z_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_RIGHT_X: right_r.x <= cfg_pwdata[15:0];
        REG_RIGHT_Y: right_r.y <= cfg_pwdata[15:0];
        REG_RIGHT_Z: right_r.z <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_RIGHT_X: cfg_prdata = {{16{right_r.x[15]}}, right_r.x};
      REG_RIGHT_Y: cfg_prdata = {{16{right_r.y[15]}}, right_r.y};
      REG_RIGHT_Z: cfg_prdata = {{16{right_r.z[15]}}, right_r.z};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  pbq_front #(
    .MAX_QUADS(MAX_QUADS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .push     (push),
    .push_data(push_data),
    .full     (full)
  );

  pbq_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (push),
    .wr_data(push_data),
    .full   (full),
    .rd_en  (pop),
    .rd_data(rd_data),
    .empty  (empty)
  );

  pbq_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .right  (right_r),
    .empty  (empty),
    .rd_data(rd_data),
    .pop    (pop),
    .out_bus(out_bus)
  );

endmodule

### hdl/pbq_checker.sv
`timescale 1ns / 1ps
// pbq_checker: port-level checks on the vertex stream of the quad expander
// bound to particle_billboard_quad_expand; no package dependency

module pbq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [12:0] out_slot,
  input logic        out_last,
  input logic [7:0]  out_a,
  input logic [7:0]  out_r
);

  logic        acc;
  logic [2:0]  k_r;
  logic [12:0] prev_slot_r;
  logic [7:0]  prev_a_r;
  logic [7:0]  prev_r_r;

  assign acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= 3'd0;
    end else if (acc) begin
      k_r <= out_last ? 3'd0 : k_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      prev_slot_r <= out_slot;
      prev_a_r    <= out_a;
      prev_r_r    <= out_r;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_a))
    else $error("vertex request changed while stalled");

  a_sixth_last: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> (out_last == (k_r == 3'd5)))
    else $error("last vertex flag not on the sixth vertex of a quad");

  a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (k_r != 3'd0) |-> (out_slot == prev_slot_r + 13'd1))
    else $error("vertex slot not consecutive within a quad");

  a_quad_color: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (k_r != 3'd0) |-> (out_a == prev_a_r) && (out_r == prev_r_r))
    else $error("color or alpha changed within a quad");

endmodule

bind particle_billboard_quad_expand pbq_checker u_pbq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_bus.valid),
  .out_ready(out_bus.ready),
  .out_slot (out_bus.vertex_slot),
  .out_last (out_bus.last_vertex),
  .out_a    (out_bus.out_a),
  .out_r    (out_bus.out_r)
);

### verif/pbq_vertex_checker.sv
`timescale 1ns / 1ps
// pbq_vertex_checker: watches the particle, vertex and cfg_ apb channels of the quad expander,
// predicts six vertices per accepted live particle and compares them in order
// depends on pbq_pkg and pbq_if

module pbq_vertex_checker
  import pbq_pkg::*;
#(
  parameter int MAX_QUADS = MAX_QUADS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  pbq_in_if                 in_mon,
  pbq_out_if                out_mon,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  input  logic [31:0]       cfg_prdata,
  input  logic              cfg_pready,
  output int                fail_count,
  output int                pending_verts
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic [7:0]         a;
    logic [12:0]        slot;
    logic               last;
  } vertex_t;

  int          corner_seq [VERTS_PER_QUAD] = '{0, 1, 2, 0, 2, 3};
  pbq_right_t  right_vec;
  int          quads_in_frame;
  vertex_t     vertex_due [$];
  logic [15:0] read_back_want;

  initial begin
    fail_count    = 0;
    pending_verts = 0;
  end

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t pbq check: %s", $time, msg);
    fail_count++;
  endtask

  task automatic queue_quad_vertices();
    longint      life, total, half, px, py, pz, rxo, ryo, rzo;
    longint      cx [4];
    longint      cy [4];
    longint      cz [4];
    logic [7:0]  alpha;
    vertex_t     v;
    int          c;
    if (in_mon.frame_start) quads_in_frame = 0;
    life = in_mon.life_left;
    // dead particles and those past MAX_QUADS in the frame emit nothing
    if (life <= 0 || quads_in_frame >= MAX_QUADS) return;
    px    = in_mon.pos_x;
    py    = in_mon.pos_y;
    pz    = in_mon.pos_z;
    half  = in_mon.edge_size >> 1;
    total = in_mon.life_total;
    if (total == 0) begin
      alpha = 8'd0;
    end else if (2 * life >= total) begin
      alpha = in_mon.color_a;
    end else begin
      alpha = 8'((longint'(in_mon.color_a) * 2 * life) / total);
    end
    rxo = (longint'(right_vec.x) * half) >>> 14;
    ryo = (longint'(right_vec.y) * half) >>> 14;
    rzo = (longint'(right_vec.z) * half) >>> 14;
    cx[0] = px - rxo; cy[0] = py - ryo - half; cz[0] = pz - rzo;
    cx[1] = px + rxo; cy[1] = py + ryo - half; cz[1] = pz + rzo;
    cx[2] = px + rxo; cy[2] = py + ryo + half; cz[2] = pz + rzo;
    cx[3] = px - rxo; cy[3] = py - ryo + half; cz[3] = pz - rzo;
    for (int k = 0; k < VERTS_PER_QUAD; k++) begin
      c      = corner_seq[k];
      v.x    = clamp32(cx[c]);
      v.y    = clamp32(cy[c]);
      v.z    = clamp32(cz[c]);
      v.r    = in_mon.color_r;
      v.g    = in_mon.color_g;
      v.b    = in_mon.color_b;
      v.a    = alpha;
      v.slot = 13'(quads_in_frame * VERTS_PER_QUAD + k);
      v.last = (k == VERTS_PER_QUAD - 1);
      vertex_due = {vertex_due, v};
    end
    quads_in_frame++;
  endtask

  task automatic match_vertex();
    vertex_t got, want;
    got.x    = out_mon.vert_x;
    got.y    = out_mon.vert_y;
    got.z    = out_mon.vert_z;
    got.r    = out_mon.out_r;
    got.g    = out_mon.out_g;
    got.b    = out_mon.out_b;
    got.a    = out_mon.out_a;
    got.slot = out_mon.vertex_slot;
    got.last = out_mon.last_vertex;
    if (vertex_due.size() == 0) begin
      flag_mismatch($sformatf("vertex slot %0d with no request pending", got.slot));
      return;
    end
    want = vertex_due.pop_front();
    if (got.x !== want.x)
      flag_mismatch($sformatf("vert_x got %0d want %0d", got.x, want.x));
    if (got.y !== want.y)
      flag_mismatch($sformatf("vert_y got %0d want %0d", got.y, want.y));
    if (got.z !== want.z)
      flag_mismatch($sformatf("vert_z got %0d want %0d", got.z, want.z));
    if (got.r !== want.r)
      flag_mismatch($sformatf("out_r got %0d want %0d", got.r, want.r));
    if (got.g !== want.g)
      flag_mismatch($sformatf("out_g got %0d want %0d", got.g, want.g));
    if (got.b !== want.b)
      flag_mismatch($sformatf("out_b got %0d want %0d", got.b, want.b));
    if (got.a !== want.a)
      flag_mismatch($sformatf("out_a got %0d want %0d", got.a, want.a));
    if (got.slot !== want.slot)
      flag_mismatch($sformatf("vertex_slot got %0d want %0d", got.slot, want.slot));
    if (got.last !== want.last)
      flag_mismatch($sformatf("last_vertex got %0b want %0b", got.last, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      right_vec      = {RIGHT_X_RST, RIGHT_Y_RST, RIGHT_Z_RST};
      quads_in_frame = 0;
      vertex_due.delete();
      pending_verts  = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (cfg_paddr[3:2])
            REG_RIGHT_X: right_vec.x = cfg_pwdata[15:0];
            REG_RIGHT_Y: right_vec.y = cfg_pwdata[15:0];
            REG_RIGHT_Z: right_vec.z = cfg_pwdata[15:0];
            default: ;
          endcase
        end else begin
          case (cfg_paddr[3:2])
            REG_RIGHT_X: read_back_want = right_vec.x;
            REG_RIGHT_Y: read_back_want = right_vec.y;
            REG_RIGHT_Z: read_back_want = right_vec.z;
            default:     read_back_want = cfg_prdata[15:0];
          endcase
          if (cfg_prdata[15:0] !== read_back_want)
            flag_mismatch($sformatf("cfg read at %0d got %h want %h", cfg_paddr,
                                    cfg_prdata[15:0], read_back_want));
        end
      end
      if (out_mon.valid && out_mon.ready) match_vertex();
      if (in_mon.valid && in_mon.ready) queue_quad_vertices();
      pending_verts = vertex_due.size();
    end
  end

endmodule

### verif/particle_billboard_quad_expand_tb.sv
`timescale 1ns / 1ps
// particle_billboard_quad_expand_tb: drives particles, vertex back-pressure and apb writes
// of the right vector into the quad expander; pbq_vertex_checker does the comparing
// depends on pbq_pkg, pbq_if, particle_billboard_quad_expand and pbq_vertex_checker

module particle_billboard_quad_expand_tb;
  import pbq_pkg::*;

  typedef struct {
    logic               frame_start;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        edge_len;
    logic signed [31:0] life_left;
    logic [30:0]        life_total;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic [7:0]         a;
  } particle_t;

  logic              clk   = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;
  int                fail_count;
  int                pending_verts;
  bit                src_idle_on = 1'b1;
  int                sent_count  = 0;

  pbq_in_if  in_if ();
  pbq_out_if out_if ();

  particle_billboard_quad_expand u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_if),
    .out_bus     (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  pbq_vertex_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .fail_count    (fail_count),
    .pending_verts (pending_verts)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic particle_t make_particle(
    input logic fs, input logic signed [31:0] px, input logic signed [31:0] py,
    input logic signed [31:0] pz, input logic [30:0] edge_len,
    input logic signed [31:0] life, input logic [30:0] total,
    input logic [7:0] r, input logic [7:0] g, input logic [7:0] b, input logic [7:0] a);
    particle_t p;
    p.frame_start = fs;
    p.pos_x       = px;
    p.pos_y       = py;
    p.pos_z       = pz;
    p.edge_len    = edge_len;
    p.life_left   = life;
    p.life_total  = total;
    p.r           = r;
    p.g           = g;
    p.b           = b;
    p.a           = a;
    return p;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7FF0_0000 + $urandom_range(0, 20'hFFFFF)
                                           : 32'h8000_0000 + $urandom_range(0, 20'hFFFFF);
      default: return int'($urandom_range(0, 4194304)) - 2097152;
    endcase
  endfunction

  function automatic particle_t rand_particle(input bit live_only);
    particle_t p;
    int        kind;
    p.frame_start = live_only ? 1'b0 : ($urandom_range(0, 15) == 0);
    p.pos_x       = rand_coord();
    p.pos_y       = rand_coord();
    p.pos_z       = rand_coord();
    if ($urandom_range(0, 3) == 0) p.edge_len = 31'($urandom);
    else p.edge_len = 31'($urandom_range(0, 4194304));
    if ($urandom_range(0, 1)) p.life_total = 31'($urandom);
    else p.life_total = 31'($urandom_range(1, 1048576));
    kind = live_only ? $urandom_range(2, 9) : $urandom_range(0, 9);
    case (kind)
      0: begin
        // dead: zero or negative life
        if ($urandom_range(0, 1)) p.life_left = 32'sd0;
        else p.life_left = $urandom | 32'h8000_0000;
      end
      1: begin
        p.life_total = 31'd0;
        p.life_left  = $urandom_range(1, 32'h7FFF_FFFF);
      end
      2, 3, 4, 5: p.life_left = $urandom_range(1, p.life_total / 2 + 1);
      default:    p.life_left = ($urandom & 32'h7FFF_FFFF) | 32'd1;
    endcase
    p.r = 8'($urandom);
    p.g = 8'($urandom);
    p.b = 8'($urandom);
    p.a = 8'($urandom);
    return p;
  endfunction

  // called and returns at a falling edge
  task automatic send_particle(input particle_t p);
    int gap;
    if (sent_count % 40 == 0) src_idle_on = ($urandom_range(0, 2) != 0);
    sent_count++;
    gap = src_idle_on ? $urandom_range(0, 7) : 0;
    while (gap > 0) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
      gap--;
    end
    in_if.valid       <= 1'b1;
    in_if.frame_start <= p.frame_start;
    in_if.pos_x       <= p.pos_x;
    in_if.pos_y       <= p.pos_y;
    in_if.pos_z       <= p.pos_z;
    in_if.edge_size   <= p.edge_len;
    in_if.life_left   <= p.life_left;
    in_if.life_total  <= p.life_total;
    in_if.color_r     <= p.r;
    in_if.color_g     <= p.g;
    in_if.color_b     <= p.b;
    in_if.color_a     <= p.a;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic reg_access(input bit wr, input logic [1:0] idx,
                            input logic signed [15:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {{16{val[15]}}, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
  endtask

  // dead or dropped particles leave no trace, so give the back end time to go idle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_verts != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // vertex sink with random stalls
  initial begin
    int gap;
    int taken;
    bit stall_on;
    out_if.ready = 1'b0;
    gap          = 0;
    taken        = 0;
    stall_on     = 1'b1;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        taken++;
        if (taken % 48 == 0) stall_on = ($urandom_range(0, 2) != 0);
        gap = stall_on ? $urandom_range(0, 7) : 0;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        gap--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic signed [15:0] rv [3];
    in_if.valid       = 1'b0;
    in_if.frame_start = 1'b0;
    in_if.pos_x       = '0;
    in_if.pos_y       = '0;
    in_if.pos_z       = '0;
    in_if.edge_size   = '0;
    in_if.life_left   = '0;
    in_if.life_total  = '0;
    in_if.color_r     = '0;
    in_if.color_g     = '0;
    in_if.color_b     = '0;
    in_if.color_a     = '0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values of the right vector
    reg_access(1'b0, REG_RIGHT_X, 16'sd0);
    reg_access(1'b0, REG_RIGHT_Y, 16'sd0);
    reg_access(1'b0, REG_RIGHT_Z, 16'sd0);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;

    // directed corners of the fields
    send_particle(make_particle(1'b1, 32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000,
                                31'h0002_0000, 32'sh0001_0000, 31'h0004_0000,
                                8'd10, 8'd20, 8'd30, 8'd200));
    send_particle(make_particle(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                31'h7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF,
                                8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_particle(make_particle(1'b0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                31'h7FFF_FFFF, 32'sd1, 31'h7FFF_FFFF,
                                8'h00, 8'h00, 8'h00, 8'hFF));
    send_particle(make_particle(1'b0, 32'sd1, 32'sd2, 32'sd3, 31'd100, 32'sd0, 31'd100,
                                8'd1, 8'd2, 8'd3, 8'd4));
    send_particle(make_particle(1'b0, 32'sd1, 32'sd2, 32'sd3, 31'd100, 32'sh8000_0000,
                                31'd100, 8'd1, 8'd2, 8'd3, 8'd4));
    // zero total life
    send_particle(make_particle(1'b0, 32'sd5, 32'sd6, 32'sd7, 31'h0001_0000, 32'sd5,
                                31'd0, 8'd9, 8'd8, 8'd7, 8'hFF));
    // fade boundary and just below it
    send_particle(make_particle(1'b0, -32'sd5, 32'sd0, 32'sd5, 31'h0003_0000,
                                32'sh0000_1000, 31'h0000_2000, 8'd1, 8'd1, 8'd1, 8'd77));
    send_particle(make_particle(1'b0, -32'sd5, 32'sd0, 32'sd5, 31'h0003_0000,
                                32'sh0000_1000, 31'h0000_2001, 8'd1, 8'd1, 8'd1, 8'd77));
    send_particle(make_particle(1'b0, 32'sd100, -32'sd100, 32'sd0, 31'd0, 32'sd50,
                                31'd60, 8'hAA, 8'h55, 8'hAA, 8'h55));
    send_particle(make_particle(1'b0, 32'sd100, -32'sd100, 32'sd0, 31'd1, 32'sd50,
                                31'd60, 8'h55, 8'hAA, 8'h55, 8'hAA));
    send_particle(make_particle(1'b0, -32'sd1, -32'sd1, -32'sd1, 31'd3, 32'sd1,
                                31'd3, 8'd128, 8'd127, 8'd64, 8'd200));
    // frame start on a dead particle still clears the quad count
    send_particle(make_particle(1'b1, 32'sd0, 32'sd0, 32'sd0, 31'd8, -32'sd1, 31'd8,
                                8'd0, 8'd0, 8'd0, 8'd0));
    send_particle(make_particle(1'b0, 32'sd0, 32'sd0, 32'sd0, 31'd8, 32'sd8, 31'd8,
                                8'd11, 8'd22, 8'd33, 8'd44));
    send_particle(make_particle(1'b1, 32'sh4000_0000, -32'sh4000_0000, 32'sd0,
                                31'h4000_0000, 32'sh7FFF_FFFF, 31'd1,
                                8'd250, 8'd5, 8'd128, 8'd99));
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: rv = '{-16'sd16384, 16'sd16384, -16'sd16384};
        1: rv = '{16'sd16384, 16'sd16384, 16'sd16384};
        2: rv = '{16'sh8000, 16'sh7FFF, 16'sh8000};
        3: rv = '{16'sd0, 16'sd0, 16'sd0};
        default: begin
          foreach (rv[k]) rv[k] = 16'(int'($urandom_range(0, 32768)) - 16384);
        end
      endcase
      reg_access(1'b1, REG_RIGHT_X, rv[0]);
      reg_access(1'b1, REG_RIGHT_Y, rv[1]);
      reg_access(1'b1, REG_RIGHT_Z, rv[2]);
      reg_access(1'b0, REG_RIGHT_X, 16'sd0);
      reg_access(1'b0, REG_RIGHT_Y, 16'sd0);
      reg_access(1'b0, REG_RIGHT_Z, 16'sd0);
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
      repeat (73) send_particle(rand_particle(1'b0));
      wait_idle();
    end

    if (fail_count == 0 && pending_verts == 0) begin
      $display("[particle_billboard_quad_expand] OK");
    end else begin
      $display("[particle_billboard_quad_expand] ERROR");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("[particle_billboard_quad_expand] ERROR");
    $finish;
  end

endmodule

### particle_billboard_quad_expand.f
hdl/pbq_pkg.sv
hdl/pbq_if.sv
hdl/pbq_fifo.sv
hdl/pbq_front.sv
hdl/pbq_back.sv
hdl/particle_billboard_quad_expand.sv
hdl/pbq_checker.sv
verif/pbq_vertex_checker.sv
verif/particle_billboard_quad_expand_tb.sv
